// ----- sv/kcl_pkg.sv -----
// ----------------------------------------------------------------------------
// kcl_pkg
// Modes, events, key codes and reset unlock time for the keypad code lock controller.
// ----------------------------------------------------------------------------
package kcl_pkg;

  typedef enum logic [2:0] {
    M_WAIT       = 3'd0,
    M_USER       = 3'd1,
    M_ADMIN      = 3'd2,
    M_MENU       = 3'd3,
    M_CHOOSE     = 3'd4,
    M_EDIT_USER  = 3'd5,
    M_EDIT_ADMIN = 3'd6,
    M_TIME       = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    EV_IGNORED = 4'd0,
    EV_MASKED  = 4'd1,
    EV_ECHO    = 4'd2,
    EV_GRANTED = 4'd3,
    EV_DENIED  = 4'd4,
    EV_MENU    = 4'd5,
    EV_PROMPT  = 4'd6,
    EV_SAVED   = 4'd7,
    EV_TIME    = 4'd8,
    EV_WAIT    = 4'd9
  } event_t;

  localparam logic [7:0] KEY_STAR       = 8'h2A;
  localparam logic [7:0] KEY_HASH       = 8'h23;
  localparam logic [7:0] KEY_ZERO       = 8'h30;
  localparam logic [7:0] KEY_ONE        = 8'h31;
  localparam logic [7:0] KEY_NINE       = 8'h39;
  localparam logic [7:0] KEY_MENU_USER  = 8'h31;
  localparam logic [7:0] KEY_MENU_TIME  = 8'h32;
  localparam logic [7:0] KEY_MENU_ADMIN = 8'h33;

  localparam logic [3:0] SECONDS_RESET  = 4'd5;

endpackage

// ----- sv/keypad_code_lock_controller.sv -----
// ----------------------------------------------------------------------------
// keypad_code_lock_controller
// Key word registered in the input stage, result in the result register.
// One key word per cycle if unstalled; state settles in the processing cycle.
// Reset: waiting mode, default codes 1234 / 1111.. and 5 s unlock time.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller import kcl_pkg::*; #(
  parameter int NUM_USERS   = 3,
  parameter int CODE_DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       key_valid,
  output logic       key_stall,
  input  logic [7:0] key_char,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [3:0] event_res,
  output logic [7:0] echo_char,
  output logic [2:0] mode_now,
  output logic [3:0] open_seconds
);

  localparam int CW = $clog2(CODE_DIGITS + 1);
  localparam int IW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int UW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;

  // input stage
  logic       kq_valid;
  logic [7:0] kq_char;
  logic       fire;

  assign fire      = kq_valid && (!res_valid || !res_stall);
  assign key_stall = kq_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      kq_valid <= 1'b0;
    end else if (key_valid && !key_stall) begin
      kq_valid <= 1'b1;
    end else if (fire) begin
      kq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (key_valid && !key_stall) begin
      kq_char <= key_char;
    end
  end

  // lock state
  mode_t          mode, mode_next;
  logic [CW-1:0]  count, count_next;
  logic [3:0]     entered    [CODE_DIGITS];
  logic [3:0]     admin_code [CODE_DIGITS];
  logic [3:0]     user_codes [NUM_USERS][CODE_DIGITS];
  logic [UW-1:0]  target;
  logic [3:0]     seconds;

  logic           is_digit, is_hash, is_star, digit_ok, last_digit, id_ok, time_ok;
  logic [3:0]     dval;
  logic [IW-1:0]  idx;
  logic [3:0]     cmp_digits [CODE_DIGITS];
  logic           admin_ok, user_ok;

  assign is_digit   = (kq_char >= KEY_ZERO) && (kq_char <= KEY_NINE);
  assign is_hash    = kq_char == KEY_HASH;
  assign is_star    = kq_char == KEY_STAR;
  assign dval       = kq_char[3:0];
  assign idx        = count[IW-1:0];
  assign digit_ok   = is_digit && (count < CW'(CODE_DIGITS));
  assign last_digit = count == CW'(CODE_DIGITS - 1);
  assign id_ok      = (kq_char >= KEY_ONE) && (kq_char <= 8'(48 + NUM_USERS));
  assign time_ok    = (kq_char >= KEY_ONE) && (kq_char <= KEY_NINE);

  always_comb begin
    for (int j = 0; j < CODE_DIGITS; j++) begin
      cmp_digits[j] = (count == CW'(j)) ? dval : entered[j];
    end
  end

  always_comb begin
    admin_ok = 1'b1;
    for (int j = 0; j < CODE_DIGITS; j++) begin
      if (cmp_digits[j] != admin_code[j]) begin
        admin_ok = 1'b0;
      end
    end
  end

  always_comb begin
    logic hit;
    user_ok = 1'b0;
    for (int i = 0; i < NUM_USERS; i++) begin
      hit = 1'b1;
      for (int j = 0; j < CODE_DIGITS; j++) begin
        if (cmp_digits[j] != user_codes[i][j]) begin
          hit = 1'b0;
        end
      end
      user_ok = user_ok | hit;
    end
  end

  // next state
  always_comb begin
    mode_next  = mode;
    count_next = count;
    if (fire) begin
      if (is_hash && (mode == M_USER || mode == M_ADMIN)) begin
        mode_next  = M_WAIT;
        count_next = '0;
      end else begin
        unique case (mode)
          M_WAIT: begin
            if (is_star) begin
              mode_next  = M_USER;
              count_next = '0;
            end else if (is_hash) begin
              mode_next  = M_ADMIN;
              count_next = '0;
            end
          end
          M_USER, M_ADMIN: begin
            if (digit_ok) begin
              if (last_digit) begin
                mode_next  = (mode == M_ADMIN && admin_ok) ? M_MENU : M_WAIT;
                count_next = '0;
              end else begin
                count_next = count + CW'(1);
              end
            end
          end
          M_MENU: begin
            if (kq_char == KEY_MENU_USER) begin
              mode_next  = M_CHOOSE;
              count_next = '0;
            end else if (kq_char == KEY_MENU_TIME) begin
              mode_next  = M_TIME;
              count_next = '0;
            end else if (kq_char == KEY_MENU_ADMIN) begin
              mode_next  = M_EDIT_ADMIN;
              count_next = '0;
            end else if (is_star) begin
              mode_next  = M_WAIT;
              count_next = '0;
            end
          end
          M_CHOOSE: begin
            if (id_ok) begin
              mode_next  = M_EDIT_USER;
              count_next = '0;
            end
          end
          M_EDIT_USER, M_EDIT_ADMIN: begin
            if (digit_ok) begin
              if (last_digit) begin
                mode_next  = M_MENU;
                count_next = '0;
              end else begin
                count_next = count + CW'(1);
              end
            end
          end
          M_TIME: begin
            if (time_ok) begin
              mode_next  = M_MENU;
              count_next = '0;
            end
          end
        endcase
      end
    end
  end

  // outputs and data writes
  event_t     ev;
  logic [7:0] echo;
  logic       wr_entry, wr_admin, wr_user, wr_target, wr_secs;

  always_comb begin
    ev        = EV_IGNORED;
    echo      = 8'h00;
    wr_entry  = 1'b0;
    wr_admin  = 1'b0;
    wr_user   = 1'b0;
    wr_target = 1'b0;
    wr_secs   = 1'b0;
    if (is_hash && (mode == M_USER || mode == M_ADMIN)) begin
      ev = EV_WAIT;
    end else begin
      unique case (mode)
        M_WAIT: begin
          if (is_star || is_hash) begin
            ev = EV_PROMPT;
          end
        end
        M_USER, M_ADMIN: begin
          if (digit_ok) begin
            wr_entry = 1'b1;
            echo     = KEY_STAR;
            if (!last_digit) begin
              ev = EV_MASKED;
            end else if (mode == M_ADMIN) begin
              ev = admin_ok ? EV_MENU : EV_DENIED;
            end else begin
              ev = user_ok ? EV_GRANTED : EV_DENIED;
            end
          end
        end
        M_MENU: begin
          if (kq_char == KEY_MENU_USER || kq_char == KEY_MENU_TIME ||
              kq_char == KEY_MENU_ADMIN) begin
            ev = EV_PROMPT;
          end else if (is_star) begin
            ev = EV_WAIT;
          end
        end
        M_CHOOSE: begin
          if (id_ok) begin
            wr_target = 1'b1;
            ev        = EV_PROMPT;
            echo      = kq_char;
          end
        end
        M_EDIT_USER, M_EDIT_ADMIN: begin
          if (digit_ok) begin
            wr_admin = mode == M_EDIT_ADMIN;
            wr_user  = mode == M_EDIT_USER;
            echo     = kq_char;
            ev       = last_digit ? EV_SAVED : EV_ECHO;
          end
        end
        M_TIME: begin
          if (time_ok) begin
            wr_secs = 1'b1;
            ev      = EV_TIME;
            echo    = kq_char;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_WAIT;
      count   <= '0;
      target  <= '0;
      seconds <= SECONDS_RESET;
      for (int j = 0; j < CODE_DIGITS; j++) begin
        admin_code[j] <= 4'((j + 1) % 10);
      end
      for (int i = 0; i < NUM_USERS; i++) begin
        for (int j = 0; j < CODE_DIGITS; j++) begin
          user_codes[i][j] <= 4'((i + 1) % 10);
        end
      end
    end else begin
      mode  <= mode_next;
      count <= count_next;
      if (fire && wr_target) begin
        target <= UW'(dval - 4'd1);
      end
      if (fire && wr_secs) begin
        seconds <= dval;
      end
      if (fire && wr_admin) begin
        admin_code[idx] <= dval;
      end
      if (fire && wr_user) begin
        user_codes[target][idx] <= dval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_entry) begin
      entered[idx] <= dval;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      event_res    <= ev;
      echo_char    <= echo;
      mode_now     <= mode_next;
      open_seconds <= wr_secs ? dval : seconds;
    end
  end

`ifndef SYNTH
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> res_valid)
    else $error("processed key word produced no result word");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CODE_DIGITS))
    else $error("digit count beyond code length");

  a_count_idle_modes: assert property (@(posedge clk) disable iff (rst)
    (mode == M_WAIT || mode == M_MENU || mode == M_CHOOSE || mode == M_TIME)
      |-> count == '0)
    else $error("digit count not cleared outside entry and edit");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    !kq_valid |-> !key_stall)
    else $error("input stalled with empty input stage");

  a_grant_returns_wait: assert property (@(posedge clk) disable iff (rst)
    (res_valid && event_res == EV_GRANTED) |-> mode_now == M_WAIT)
    else $error("granted result not in waiting mode");
`endif

endmodule

// ----- test/tb_keypad_code_lock_controller.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keypad_code_lock_controller
// Drives key words into the code lock and predicts each result word from a
// behavioral model of the lock state (mode, digit count, stored codes and
// unlock time). Directed key sequences are followed by random sessions under
// four handshake phases.
// ----------------------------------------------------------------------------
module tb_keypad_code_lock_controller import kcl_pkg::*;;

  localparam int USERS  = 3;
  localparam int DIGITS = 4;

  typedef struct packed {
    event_t     ev;
    logic [7:0] echo;
    mode_t      mode;
    logic [3:0] secs;
  } lock_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       key_valid = 1'b0;
  logic [7:0] key_char = 8'h00;
  logic       res_stall = 1'b0;
  logic       key_stall;
  logic       res_valid;
  logic [3:0] event_res;
  logic [7:0] echo_char;
  logic [2:0] mode_now;
  logic [3:0] open_seconds;

  // lock state as predicted
  mode_t               lock_mode;
  int                  lock_count;
  logic [4*DIGITS-1:0] lock_entered;
  logic [4*DIGITS-1:0] lock_admin;
  logic [4*DIGITS-1:0] lock_users [USERS];
  logic [1:0]          lock_target;
  logic [3:0]          lock_secs;

  lock_result_t response_q [$];
  lock_result_t want;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int keys_sent = 0;
  int keys_ignored = 0;
  int words_checked = 0;
  int errors = 0;
  int ev_seen [16];

  keypad_code_lock_controller #(
    .NUM_USERS   (USERS),
    .CODE_DIGITS (DIGITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .key_valid    (key_valid),
    .key_stall    (key_stall),
    .key_char     (key_char),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .event_res    (event_res),
    .echo_char    (echo_char),
    .mode_now     (mode_now),
    .open_seconds (open_seconds)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void reset_lock_model();
    lock_mode = M_WAIT;
    lock_count = 0;
    lock_target = '0;
    lock_secs = SECONDS_RESET;
    lock_entered = '0;
    for (int j = 0; j < DIGITS; j++) begin
      lock_admin[4*j +: 4] = 4'((j + 1) % 10);
      for (int i = 0; i < USERS; i++) begin
        lock_users[i][4*j +: 4] = 4'((i + 1) % 10);
      end
    end
  endfunction

  function automatic void enter_mode(input mode_t m);
    lock_mode = m;
    lock_count = 0;
  endfunction

  // applies one key to the lock state, returns the result word it causes
  function automatic lock_result_t lock_response(input logic [7:0] k);
    lock_result_t r;
    logic         is_dig;
    logic [3:0]   dv;
    logic         hit;
    r.ev = EV_IGNORED;
    r.echo = 8'h00;
    is_dig = (k >= KEY_ZERO) && (k <= KEY_NINE);
    dv = k[3:0];
    if (k == KEY_HASH && (lock_mode == M_USER || lock_mode == M_ADMIN)) begin
      enter_mode(M_WAIT);
      r.ev = EV_WAIT;
    end else begin
      case (lock_mode)
        M_WAIT: begin
          if (k == KEY_STAR) begin
            enter_mode(M_USER);
            r.ev = EV_PROMPT;
          end else if (k == KEY_HASH) begin
            enter_mode(M_ADMIN);
            r.ev = EV_PROMPT;
          end
        end
        M_USER, M_ADMIN: begin
          if (is_dig && lock_count < DIGITS) begin
            lock_entered[4*lock_count +: 4] = dv;
            lock_count++;
            r.echo = KEY_STAR;
            r.ev = EV_MASKED;
            if (lock_count == DIGITS) begin
              if (lock_mode == M_ADMIN) begin
                if (lock_entered == lock_admin) begin
                  enter_mode(M_MENU);
                  r.ev = EV_MENU;
                end else begin
                  enter_mode(M_WAIT);
                  r.ev = EV_DENIED;
                end
              end else begin
                hit = 1'b0;
                for (int i = 0; i < USERS; i++) begin
                  if (lock_entered == lock_users[i]) hit = 1'b1;
                end
                enter_mode(M_WAIT);
                r.ev = hit ? EV_GRANTED : EV_DENIED;
              end
            end
          end
        end
        M_MENU: begin
          if (k == KEY_MENU_USER) begin
            enter_mode(M_CHOOSE);
            r.ev = EV_PROMPT;
          end else if (k == KEY_MENU_TIME) begin
            enter_mode(M_TIME);
            r.ev = EV_PROMPT;
          end else if (k == KEY_MENU_ADMIN) begin
            enter_mode(M_EDIT_ADMIN);
            r.ev = EV_PROMPT;
          end else if (k == KEY_STAR) begin
            enter_mode(M_WAIT);
            r.ev = EV_WAIT;
          end
        end
        M_CHOOSE: begin
          if (k >= KEY_ONE && k <= KEY_ZERO + USERS) begin
            lock_target = 2'(dv - 4'd1);
            enter_mode(M_EDIT_USER);
            r.ev = EV_PROMPT;
            r.echo = k;
          end
        end
        M_EDIT_USER, M_EDIT_ADMIN: begin
          if (is_dig && lock_count < DIGITS) begin
            if (lock_mode == M_EDIT_ADMIN) lock_admin[4*lock_count +: 4] = dv;
            else if (lock_target < USERS) lock_users[lock_target][4*lock_count +: 4] = dv;
            lock_count++;
            r.echo = k;
            r.ev = EV_ECHO;
            if (lock_count == DIGITS) begin
              enter_mode(M_MENU);
              r.ev = EV_SAVED;
            end
          end
        end
        default: begin
          if (k >= KEY_ONE && k <= KEY_NINE) begin
            lock_secs = dv;
            enter_mode(M_MENU);
            r.ev = EV_TIME;
            r.echo = k;
          end
        end
      endcase
    end
    r.mode = lock_mode;
    r.secs = lock_secs;
    return r;
  endfunction

  function automatic logic [4*DIGITS-1:0] random_code();
    logic [4*DIGITS-1:0] c;
    for (int j = 0; j < DIGITS; j++) c[4*j +: 4] = 4'($urandom_range(9));
    return c;
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  task automatic send_key(input logic [7:0] k);
    lock_result_t r;
    key_valid <= 1'b1;
    key_char <= k;
    @(posedge clk);
    while (key_stall) @(posedge clk);
    r = lock_response(k);
    response_q.push_back(r);
    keys_sent++;
    if (r.ev == EV_IGNORED) keys_ignored++;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      key_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_all_results();
    key_valid <= 1'b0;
    @(posedge clk);
    while (response_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_code(input logic [4*DIGITS-1:0] code, input int noise_pct);
    for (int j = 0; j < DIGITS; j++) begin
      if ($urandom_range(99) < noise_pct) send_key(8'($urandom_range(255)));
      send_key(KEY_ZERO + code[4*j +: 4]);
    end
  endtask

  task automatic return_to_waiting();
    while (lock_mode != M_WAIT) begin
      case (lock_mode)
        M_USER, M_ADMIN: send_key(KEY_HASH);
        M_MENU: send_key(KEY_STAR);
        M_CHOOSE: send_key(8'(KEY_ONE + $urandom_range(USERS - 1)));
        M_TIME: send_key(8'(KEY_ONE + $urandom_range(8)));
        default: send_key(8'(KEY_ZERO + $urandom_range(9)));
      endcase
    end
  endtask

  task automatic user_session();
    int pick;
    send_key(KEY_STAR);
    if ($urandom_range(19) == 0) begin
      send_key(KEY_HASH);
    end else begin
      pick = $urandom_range(99);
      if (pick < 50) send_code(lock_users[$urandom_range(USERS - 1)], 6);
      else if (pick < 60) send_code(lock_admin, 6);
      else send_code(random_code(), 6);
    end
  endtask

  task automatic menu_action();
    case ($urandom_range(3))
      0: begin
        send_key(KEY_MENU_TIME);
        if ($urandom_range(99) < 75) send_key(8'(KEY_ONE + $urandom_range(8)));
        else send_key(8'($urandom_range(255)));
      end
      1: begin
        send_key(KEY_MENU_USER);
        if ($urandom_range(99) < 75) send_key(8'(KEY_ONE + $urandom_range(USERS - 1)));
        else send_key(8'($urandom_range(255)));
        if (lock_mode == M_EDIT_USER) send_code(random_code(), 5);
      end
      2: begin
        send_key(KEY_MENU_ADMIN);
        send_code($urandom_range(1) ? random_code() : lock_admin, 5);
      end
      default: send_key(8'($urandom_range(255)));
    endcase
  endtask

  task automatic admin_session();
    send_key(KEY_HASH);
    send_code(($urandom_range(99) < 80) ? lock_admin : random_code(), 4);
    repeat ($urandom_range(1, 4)) begin
      if (lock_mode == M_MENU) menu_action();
    end
    if (lock_mode == M_MENU) send_key(KEY_STAR);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(4))
        0: send_key(KEY_ZERO);
        1: send_key(KEY_NINE);
        2: send_key(KEY_STAR);
        3: send_key(KEY_HASH);
        default: send_key(8'($urandom_range(255)));
      endcase
    end
  endtask

  // default user code grants; stray keys in waiting mode are ignored
  task automatic test_user_unlock();
    send_key(KEY_STAR);
    send_code({4{4'd1}}, 0);
    send_key(8'h00);
    send_key(8'hFF);
  endtask

  task automatic test_cancel_entry();
    send_key(KEY_STAR);
    send_key(KEY_HASH);
    send_key(KEY_HASH);
    send_key(KEY_HASH);
  endtask

  // default admin code, longest unlock time, user 3 and admin code rewritten
  task automatic test_admin_menu();
    send_key(KEY_HASH);
    send_code(lock_admin, 0);
    send_key(KEY_MENU_TIME);
    send_key(KEY_NINE);
    send_key(KEY_MENU_USER);
    send_key(8'(KEY_ZERO + USERS));
    send_code({4'd9, 4'd0, 4'd9, 4'd0}, 0);
    send_key(KEY_MENU_ADMIN);
    send_code({4'd6, 4'd7, 4'd8, 4'd9}, 0);
    send_key(KEY_STAR);
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int goal);
    int start;
    send_idle_pct = idle;
    stall_pct = stall;
    start = keys_sent;
    while (keys_sent - start < goal) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: user_session();
        7, 8, 9, 10, 11, 12, 13, 14, 15: admin_session();
        default: noise_burst();
      endcase
      return_to_waiting();
    end
    wait_all_results();
  endtask

  always @(posedge clk) begin
    res_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (response_q.size() == 0) begin
        note_error($sformatf("result word with none pending: event %0d echo %h mode %0d",
                             event_res, echo_char, mode_now));
      end else begin
        want = response_q.pop_front();
        words_checked++;
        ev_seen[want.ev]++;
        if (event_res !== want.ev || echo_char !== want.echo ||
            mode_now !== want.mode || open_seconds !== want.secs) begin
          note_error($sformatf({"word %0d exp/got: event %0d/%0d echo %h/%h",
                                " mode %0d/%0d secs %0d/%0d"}, words_checked,
                               want.ev, event_res, want.echo, echo_char,
                               want.mode, mode_now, want.secs, open_seconds));
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    reset_lock_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_user_unlock();
    test_cancel_entry();
    test_admin_menu();
    wait_all_results();
    test_random_traffic(0, 0, 130);
    test_random_traffic(85, 0, 130);
    test_random_traffic(0, 85, 130);
    test_random_traffic(18, 18, 130);
    repeat (10) @(posedge clk);
    if (response_q.size() != 0) note_error("result words still pending at end of run");
    $display("Sent %0d keys (%0d ignored), checked %0d result words over four handshake phases.",
             keys_sent, keys_ignored, words_checked);
    $display("Grants %0d, denials %0d, menu opens %0d, codes saved %0d, time sets %0d.",
             ev_seen[EV_GRANTED], ev_seen[EV_DENIED], ev_seen[EV_MENU],
             ev_seen[EV_SAVED], ev_seen[EV_TIME]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d errors", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- keypad_code_lock_controller.f -----
sv/kcl_pkg.sv
sv/keypad_code_lock_controller.sv
test/tb_keypad_code_lock_controller.sv
